FILE: sv/cmmdd_pkg.sv
// shared constants, operand types and sequencer-to-datapath control for the
// conjugate-transpose complex matrix product; no dependencies
`default_nettype none

package cmmdd_pkg;

   localparam int MAT_DIM     = 3;
   localparam int FRAC_BITS   = 30;
   localparam int STORE_DEPTH = MAT_DIM * MAT_DIM;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);
   localparam int DIM_W       = $clog2(MAT_DIM);
   localparam int IDX_W       = 6;
   localparam int DATA_W      = 32;
   localparam int PROD_W      = 2 * DATA_W;
   // room for 2*MAT_DIM full-scale products plus the rounding constant
   localparam int ACC_W       = PROD_W + $clog2(2 * MAT_DIM) + 2;
   localparam int REQ_DATA_W  = 136;
   localparam int RSP_DATA_W  = 72;

   typedef struct packed {
      logic signed [DATA_W-1:0] im;
      logic signed [DATA_W-1:0] re;
   } cplx_type;

   // the four partial products of conj(b) * conj(c)
   typedef enum logic [1:0] {
      OP_RE_ADD,
      OP_RE_SUB,
      OP_IM_SUB_RI,
      OP_IM_SUB_IR
   } mac_op_type;

   typedef struct packed {
      logic       clear;
      logic       issue;
      mac_op_type op;
      logic       finish;
   } mac_ctrl_type;

endpackage

`default_nettype wire

FILE: sv/cmmdd_store.sv
// element stores for matrices b and c: one write port, registered reads
// depends on cmmdd_pkg
`default_nettype none

module cmmdd_store (
   input  wire                            clock,
   input  wire                            wr_en,
   input  wire [cmmdd_pkg::STORE_AW-1:0]  wr_addr,
   input  cmmdd_pkg::cplx_type            wr_b,
   input  cmmdd_pkg::cplx_type            wr_c,
   input  wire                            rd_en,
   input  wire [cmmdd_pkg::STORE_AW-1:0]  rd_b_addr,
   input  wire [cmmdd_pkg::STORE_AW-1:0]  rd_c_addr,
   output cmmdd_pkg::cplx_type            rd_b,
   output cmmdd_pkg::cplx_type            rd_c
);
   import cmmdd_pkg::*;

   cplx_type b_mem_ff [STORE_DEPTH];
   cplx_type c_mem_ff [STORE_DEPTH];
   cplx_type rd_b_ff;
   cplx_type rd_c_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         b_mem_ff[wr_addr] <= wr_b;
         c_mem_ff[wr_addr] <= wr_c;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_b_ff <= b_mem_ff[rd_b_addr];
         rd_c_ff <= c_mem_ff[rd_c_addr];
      end
   end

   assign rd_b = rd_b_ff;
   assign rd_c = rd_c_ff;

endmodule

`default_nettype wire

FILE: sv/cmmdd_mac.sv
// shared 32x32 multiplier with wide real and imaginary accumulators,
// round half up and saturation to q1.30; depends on cmmdd_pkg
`default_nettype none

module cmmdd_mac (
   input  wire                            clock,
   input  wire                            reset,
   input  cmmdd_pkg::mac_ctrl_type        ctrl,
   input  cmmdd_pkg::cplx_type            op_b,
   input  cmmdd_pkg::cplx_type            op_c,
   output wire [cmmdd_pkg::DATA_W-1:0]    res_re,
   output wire [cmmdd_pkg::DATA_W-1:0]    res_im,
   output wire                            res_sat
);
   import cmmdd_pkg::*;

   localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_BITS - 1);

   function automatic logic [DATA_W:0] round_sat(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] sum;
      logic signed [ACC_W-1:0] sh;
      logic [DATA_W:0]         r;
      sum = v + ROUND_HALF;
      sh  = sum >>> FRAC_BITS;
      // fits when everything above bit 30 is pure sign
      if (&sh[ACC_W-1:DATA_W-1] || ~|sh[ACC_W-1:DATA_W-1]) begin
         r = {1'b0, sh[DATA_W-1:0]};
      end else begin
         r = {1'b1, sh[ACC_W-1], {(DATA_W-1){~sh[ACC_W-1]}}};
      end
      return r;
   endfunction

   logic signed [DATA_W-1:0] mul_a;
   logic signed [DATA_W-1:0] mul_b;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] prod_ff;
   mac_op_type               prod_op_ff;
   logic                     prod_valid_ff;
   logic signed [ACC_W-1:0]  prod_ext;
   logic signed [ACC_W-1:0]  addend;
   logic signed [ACC_W-1:0]  acc_sum;
   logic                     to_re;
   logic signed [ACC_W-1:0]  acc_re_ff;
   logic signed [ACC_W-1:0]  acc_im_ff;
   logic [DATA_W:0]          fin_re;
   logic [DATA_W:0]          fin_im;
   logic [DATA_W-1:0]        res_re_ff;
   logic [DATA_W-1:0]        res_im_ff;
   logic                     res_sat_ff;

   always_comb begin
      case (ctrl.op)
         OP_RE_ADD: begin
            mul_a = op_b.re;
            mul_b = op_c.re;
         end
         OP_RE_SUB: begin
            mul_a = op_b.im;
            mul_b = op_c.im;
         end
         OP_IM_SUB_RI: begin
            mul_a = op_b.re;
            mul_b = op_c.im;
         end
         default: begin
            mul_a = op_b.im;
            mul_b = op_c.re;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= ctrl.issue;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.issue) begin
         prod_ff    <= prod_in;
         prod_op_ff <= ctrl.op;
      end
   end

   // only the first real term is added, the other three are subtracted
   assign prod_ext = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign addend   = (prod_op_ff == OP_RE_ADD) ? prod_ext : -prod_ext;
   assign to_re    = (prod_op_ff == OP_RE_ADD) || (prod_op_ff == OP_RE_SUB);
   assign acc_sum  = (to_re ? acc_re_ff : acc_im_ff) + addend;

   always_ff @(posedge clock) begin
      if (ctrl.clear) begin
         acc_re_ff <= '0;
         acc_im_ff <= '0;
      end else if (prod_valid_ff) begin
         if (to_re) begin
            acc_re_ff <= acc_sum;
         end else begin
            acc_im_ff <= acc_sum;
         end
      end
   end

   assign fin_re = round_sat(acc_re_ff);
   assign fin_im = round_sat(acc_im_ff);

   always_ff @(posedge clock) begin
      if (ctrl.finish) begin
         res_re_ff  <= fin_re[DATA_W-1:0];
         res_im_ff  <= fin_im[DATA_W-1:0];
         res_sat_ff <= fin_re[DATA_W] | fin_im[DATA_W];
      end
   end

   assign res_re  = res_re_ff;
   assign res_im  = res_im_ff;
   assign res_sat = res_sat_ff;

endmodule

`default_nettype wire

FILE: sv/complex_matrix_multiply_dagger_dagger.sv
// top level: load sequencer and product sequencer around the element stores
// and the shared multiply-accumulate unit; depends on cmmdd_pkg, cmmdd_store, cmmdd_mac
//
//   channel | direction | handshake             | contents
//   req     | in        | req_tvalid/req_tready | element pair, tlast starts the product
//   rsp     | out       | rsp_tvalid/rsp_tready | one element of the product matrix
//
// a request without tlast starts nothing; the block stays idle with req_tready high.
// a request with tlast starts the product: each of the MAT_DIM*MAT_DIM results comes from
// the single multiplier doing four partial products per term after one store read, plus
// drain and rounding.
// req_tready stays low until the last result has been taken; rsp stalls simply hold the result.
// synchronous active-high reset returns the sequencer to idle; store contents are kept.
`default_nettype none

module complex_matrix_multiply_dagger_dagger (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   output wire                              req_tready,
   // elem_index, b_real, b_imag, c_real, c_imag, zero pad
   input  wire [cmmdd_pkg::REQ_DATA_W-1:0]  req_tdata,
   // load_last
   input  wire                              req_tlast,
   output wire                              rsp_tvalid,
   input  wire                              rsp_tready,
   // out_index, a_real, a_imag, zero pad
   output wire [cmmdd_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // saturated
   output wire                              rsp_tuser,
   // out_last
   output wire                              rsp_tlast
);
   import cmmdd_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_MUL,
      ST_DRAIN,
      ST_FINISH,
      ST_EMIT
   } state_type;

   localparam logic [DIM_W-1:0] DIM_LAST = DIM_W'(MAT_DIM - 1);

   state_type        state_ff, state_in;
   logic [DIM_W-1:0] i_ff, i_in;
   logic [DIM_W-1:0] j_ff, j_in;
   logic [DIM_W-1:0] m_ff, m_in;
   mac_op_type       op_ff, op_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0] rsp_index_ff, rsp_index_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             req_fire;
   logic             rsp_fire;
   logic [IDX_W-1:0] elem_index;
   logic             index_ok;
   logic             wr_en;
   cplx_type         wr_b;
   cplx_type         wr_c;
   cplx_type         rd_b;
   cplx_type         rd_c;
   logic [STORE_AW-1:0] rd_b_addr;
   logic [STORE_AW-1:0] rd_c_addr;
   mac_ctrl_type     mac_ctrl;
   logic [DATA_W-1:0] res_re;
   logic [DATA_W-1:0] res_im;
   logic             res_sat;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_valid_ff && rsp_tready;

   assign elem_index = req_tdata[IDX_W-1:0];
   assign index_ok   = {1'b0, elem_index} < (IDX_W + 1)'(STORE_DEPTH);
   assign wr_en      = req_fire && index_ok;
   assign wr_b       = cplx_type'(req_tdata[IDX_W + 2*DATA_W - 1:IDX_W]);
   assign wr_c       = cplx_type'(req_tdata[IDX_W + 4*DATA_W - 1:IDX_W + 2*DATA_W]);

   // b is read down column i, c along row j
   assign rd_b_addr = STORE_AW'(m_ff * MAT_DIM + i_ff);
   assign rd_c_addr = STORE_AW'(j_ff * MAT_DIM + m_ff);

   assign mac_ctrl.clear  = (state_ff == ST_IDLE) || ((state_ff == ST_EMIT) && rsp_fire);
   assign mac_ctrl.issue  = (state_ff == ST_MUL);
   assign mac_ctrl.op     = op_ff;
   assign mac_ctrl.finish = (state_ff == ST_FINISH);

   cmmdd_store u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (elem_index[STORE_AW-1:0]),
      .wr_b      (wr_b),
      .wr_c      (wr_c),
      .rd_en     (state_ff == ST_READ),
      .rd_b_addr (rd_b_addr),
      .rd_c_addr (rd_c_addr),
      .rd_b      (rd_b),
      .rd_c      (rd_c)
   );

   cmmdd_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (mac_ctrl),
      .op_b    (rd_b),
      .op_c    (rd_c),
      .res_re  (res_re),
      .res_im  (res_im),
      .res_sat (res_sat)
   );

   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      m_in         = m_ff;
      op_in        = op_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_index_in = rsp_index_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_tlast) begin
               state_in = ST_READ;
               i_in     = '0;
               j_in     = '0;
               m_in     = '0;
               op_in    = OP_RE_ADD;
            end
         end
         ST_READ: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            unique case (op_ff)
               OP_RE_ADD:    op_in = OP_RE_SUB;
               OP_RE_SUB:    op_in = OP_IM_SUB_RI;
               OP_IM_SUB_RI: op_in = OP_IM_SUB_IR;
               default: begin
                  op_in = OP_RE_ADD;
                  if (m_ff == DIM_LAST) begin
                     m_in     = '0;
                     state_in = ST_DRAIN;
                  end else begin
                     m_in     = m_ff + 1'b1;
                     state_in = ST_READ;
                  end
               end
            endcase
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            state_in     = ST_EMIT;
            rsp_valid_in = 1'b1;
            rsp_index_in = IDX_W'(i_ff * MAT_DIM + j_ff);
            rsp_last_in  = (i_ff == DIM_LAST) && (j_ff == DIM_LAST);
         end
         ST_EMIT: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_READ;
                  if (j_ff == DIM_LAST) begin
                     j_in = '0;
                     i_in = i_ff + 1'b1;
                  end else begin
                     j_in = j_ff + 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         i_ff         <= '0;
         j_ff         <= '0;
         m_ff         <= '0;
         op_ff        <= OP_RE_ADD;
         rsp_valid_ff <= 1'b0;
         rsp_index_ff <= '0;
         rsp_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         m_ff         <= m_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_index_ff <= rsp_index_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - IDX_W - 2*DATA_W){1'b0}}, res_im, res_re, rsp_index_ff};
   assign rsp_tuser  = res_sat;
   assign rsp_tlast  = rsp_last_ff;

   // the block never takes a request while a result is pending
   assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request accepted while a result is pending");

   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("product did not start after final element");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready)
      else $error("block not ready after final result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[IDX_W-1:0] == IDX_W'(STORE_DEPTH - 1))
      else $error("final result carries wrong index");

endmodule

`default_nettype wire

FILE: sim/cmmdd_tb_pkg.sv
// request and product element types plus the scoreboard for the conjugate-transpose
// complex matrix product; keeps its own copy of both element stores; needs cmmdd_pkg
`timescale 1ns / 1ps

package cmmdd_tb_pkg;
   import cmmdd_pkg::*;

   typedef struct packed {
      logic [IDX_W-1:0]  idx;
      logic [DATA_W-1:0] b_re, b_im, c_re, c_im;
      logic              last;
   } pair_req_type;

   typedef struct packed {
      logic [IDX_W-1:0]  idx;
      logic [DATA_W-1:0] re;
      logic [DATA_W-1:0] im;
      logic              sat;
      logic              last;
   } prod_elem_type;

   // six full-scale products per sum plus rounding fit easily
   typedef logic signed [79:0] wide_type;

   localparam wide_type Q_MAX = (wide_type'(1) <<< (DATA_W - 1)) - 1;
   localparam wide_type Q_MIN = -(wide_type'(1) <<< (DATA_W - 1));

   class dagger_product_board;
      cplx_type      b_mat [STORE_DEPTH];
      cplx_type      c_mat [STORE_DEPTH];
      prod_elem_type expected_elems [$];
      int            mismatches;

      function new();
         mismatches = 0;
      endfunction

      // round half up, drop the fraction, then clip to the word range
      function logic [DATA_W-1:0] round_clip(input wide_type sum, inout logic sat);
         wide_type q;
         q = (sum + (wide_type'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
         if (q > Q_MAX) begin
            sat = 1'b1;
            return Q_MAX[DATA_W-1:0];
         end
         if (q < Q_MIN) begin
            sat = 1'b1;
            return Q_MIN[DATA_W-1:0];
         end
         return q[DATA_W-1:0];
      endfunction

      // store an in-range element pair; a last mark queues the whole product matrix
      function void load_pair(input pair_req_type p);
         prod_elem_type e;
         cplx_type      bw, cw;
         wide_type      br, bi, cr, ci, re_sum, im_sum;
         logic          sat;
         if (p.idx < STORE_DEPTH) begin
            b_mat[p.idx] = {p.b_im, p.b_re};
            c_mat[p.idx] = {p.c_im, p.c_re};
         end
         if (!p.last)
            return;
         for (int i = 0; i < MAT_DIM; i++) begin
            for (int j = 0; j < MAT_DIM; j++) begin
               re_sum = '0;
               im_sum = '0;
               sat    = 1'b0;
               for (int m = 0; m < MAT_DIM; m++) begin
                  bw = b_mat[m * MAT_DIM + i];
                  cw = c_mat[j * MAT_DIM + m];
                  br = $signed(bw.re);
                  bi = $signed(bw.im);
                  cr = $signed(cw.re);
                  ci = $signed(cw.im);
                  // conj(b) * conj(c) is conj(b * c)
                  re_sum = re_sum + br * cr - bi * ci;
                  im_sum = im_sum - br * ci - bi * cr;
               end
               e.re   = round_clip(re_sum, sat);
               e.im   = round_clip(im_sum, sat);
               e.idx  = IDX_W'(i * MAT_DIM + j);
               e.sat  = sat;
               e.last = (i == MAT_DIM - 1) && (j == MAT_DIM - 1);
               expected_elems.push_back(e);
            end
         end
      endfunction

      function void check_elem(input prod_elem_type got);
         prod_elem_type want;
         if (expected_elems.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected product element: idx %0d re %h im %h sat %0b last %0b",
                        got.idx, got.re, got.im, got.sat, got.last);
            return;
         end
         want = expected_elems.pop_front();
         if (got.idx !== want.idx || got.re !== want.re || got.im !== want.im ||
             got.sat !== want.sat || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("product element mismatch: expected idx %0d re %h im %h sat %0b last %0b",
                        want.idx, want.re, want.im, want.sat, want.last);
               $display("                           got      idx %0d re %h im %h sat %0b last %0b",
                        got.idx, got.re, got.im, got.sat, got.last);
            end
         end
      endfunction

      function int pending();
         return expected_elems.size();
      endfunction
   endclass

endpackage

FILE: sim/tb_top.sv
// simulation top: clock, reset, request bursts and response stalls around
// complex_matrix_multiply_dagger_dagger; needs cmmdd_pkg and cmmdd_tb_pkg
`timescale 1ns / 1ps

module tb_top;
   import cmmdd_pkg::*;
   import cmmdd_tb_pkg::*;

   localparam int RAND_ITEMS  = 250;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int ELEM_CYCLES = MAT_DIM * 5 + 3;

   localparam logic [DATA_W-1:0] WORD_MAX = {1'b0, {(DATA_W - 1){1'b1}}};
   localparam logic [DATA_W-1:0] WORD_MIN = {1'b1, {(DATA_W - 1){1'b0}}};

   typedef enum int {SCALE_SMALL, SCALE_MIXED, SCALE_FULL} scale_type;
   typedef enum int {RX_FREE, RX_EVERY_THIRD, RX_COIN, RX_HOLD} rx_pattern_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   wire                   req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tlast  = 1'b0;
   wire                   rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   wire  [RSP_DATA_W-1:0] rsp_tdata;
   wire                   rsp_tuser;
   wire                   rsp_tlast;

   dagger_product_board board;
   int                  cycle_count = 0;
   int                  stall_left  = 0;
   rx_pattern_type      stall_mode  = RX_FREE;

   complex_matrix_multiply_dagger_dagger u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_elem('{idx:  rsp_tdata[IDX_W-1:0],
                            re:   rsp_tdata[IDX_W +: DATA_W],
                            im:   rsp_tdata[IDX_W + DATA_W +: DATA_W],
                            sat:  rsp_tuser,
                            last: rsp_tlast});
   end

   // receiver stalls follow a random pattern, rechosen when its random countdown ends
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = rx_pattern_type'($urandom_range(3));
         stall_left = $urandom_range(8, 40);
      end
      stall_left = stall_left - 1;
      case (stall_mode)
         RX_FREE:        rsp_tready <= 1'b1;
         RX_EVERY_THIRD: rsp_tready <= (stall_left % 3) != 0;
         RX_COIN:        rsp_tready <= 1'($urandom_range(1));
         default:        rsp_tready <= stall_left < 4;
      endcase
   end

   function automatic logic [DATA_W-1:0] pick_word(input scale_type scale);
      logic [DATA_W-1:0] r;
      r = $urandom;
      if (scale == SCALE_SMALL)
         return {{(DATA_W - 24){r[23]}}, r[23:0]};
      if (scale == SCALE_FULL)
         return r;
      case ($urandom_range(5))
         0:       return WORD_MAX;
         1:       return WORD_MIN;
         2:       return '0;
         3:       return {{(DATA_W - 24){r[23]}}, r[23:0]};
         default: return r;
      endcase
   endfunction

   function automatic pair_req_type make_pair(input int idx, input logic [DATA_W-1:0] br, bi,
                                              cr, ci, input logic last);
      pair_req_type p;
      p.idx  = IDX_W'(idx);
      p.b_re = br;
      p.b_im = bi;
      p.c_re = cr;
      p.c_im = ci;
      p.last = last;
      return p;
   endfunction

   task automatic send_pair(input pair_req_type p);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'({p.c_im, p.c_re, p.b_im, p.b_re, p.idx});
      req_tlast  <= p.last;
      do @(posedge clock); while (!req_tready);
      board.load_pair(p);
   endtask

   task automatic pause(input int n);
      @(negedge clock);
      req_tvalid <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   initial begin
      pair_req_type p;
      scale_type    scale;
      int           frame_len;
      int           burst_left;
      int           counted;
      bit           broken;
      board      = new();
      burst_left = 0;
      counted    = 0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // every part at the most negative value, product on the last write
      for (int k = 0; k < STORE_DEPTH; k++)
         send_pair(make_pair(k, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN,
                             k == STORE_DEPTH - 1));
      // zero matrices apart from one element, loaded without a last mark
      for (int k = 0; k < STORE_DEPTH; k++) begin
         if (k == 4)
            send_pair(make_pair(k, 1 << 15, 1 << 14, 1 << 14, -(1 << 15), 1'b0));
         else
            send_pair(make_pair(k, '0, '0, '0, '0, 1'b0));
         if (k[0])
            pause(k);
      end
      // out of range without last is dropped; with last it still starts the product
      send_pair(make_pair(STORE_DEPTH, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, 1'b0));
      send_pair(make_pair(6'h3f, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, 1'b1));
      // full-scale parts of both signs drive the sums into clipping
      for (int k = 0; k < 4; k++)
         send_pair(make_pair(k, WORD_MAX, k[0] ? WORD_MAX : WORD_MIN, WORD_MAX,
                             WORD_MAX, k == 3));

      while (counted < RAND_ITEMS) begin
         frame_len = $urandom_range(1, 12);
         scale     = scale_type'($urandom_range(2));
         broken    = $urandom_range(9) == 0;
         for (int k = 0; k < frame_len; k++) begin
            p.idx  = ($urandom_range(9) == 0) ? IDX_W'($urandom_range(63))
                                              : IDX_W'($urandom_range(STORE_DEPTH - 1));
            p.b_re = pick_word(scale);
            p.b_im = pick_word(scale);
            p.c_re = pick_word(scale);
            p.c_im = pick_word(scale);
            p.last = (k == frame_len - 1) && !broken;
            if (burst_left == 0) begin
               pause($urandom_range(1, 6));
               burst_left = ($urandom_range(7) == 0) ? 60 : $urandom_range(1, 8);
            end
            burst_left--;
            send_pair(p);
            if (p.idx < STORE_DEPTH || p.last)
               counted++;
         end
      end
      pause(1);

      while (board.pending() != 0)
         @(posedge clock);
      repeat (4 * ELEM_CYCLES) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

FILE: complex_matrix_multiply_dagger_dagger.f
sv/cmmdd_pkg.sv
sv/cmmdd_store.sv
sv/cmmdd_mac.sv
sv/complex_matrix_multiply_dagger_dagger.sv
sim/cmmdd_tb_pkg.sv
sim/tb_top.sv
